@@ rtl/mwl1_pkg.sv @@
`default_nettype none

package mwl1_pkg;

  localparam int unsigned DIST_W   = 36;
  localparam int unsigned WSUM_W   = 28;
  localparam int unsigned PROD_W   = 24;
  localparam int unsigned COST_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] UNIT_WEIGHT = 16'd256;
  localparam logic [15:0] COST_MAX    = 16'hFF00;
  localparam logic [15:0] DENSE_WEIGHT_RST = 16'd256;
  localparam logic [7:0]  EMPTY_CODE_RST   = 8'd0;
  localparam logic [7:0]  TARGET_CODE_RST  = 8'd1;

  localparam logic [CFG_IDX_W-1:0] REG_DENSE_WEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CODE  = 2'd2;

  typedef struct packed {
    logic [7:0] mask_status;
    logic [7:0] dense_value;
    logic [7:0] sparse_value;
    logic [7:0] dictionary_value;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [15:0] cost;
    logic        zero_weight;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PRE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/masked_weighted_l1_patch_cost.sv @@
`default_nettype none

// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     item   (item_t)
// result    out        result_valid / result_stall result (result_t)
// cfg       in         cfg_write                   cfg_index, cfg_data
//
// A word that is not the last of a patch passes through accept, multiply and
// saturating accumulate. A last word adds a range check, 16 restoring divide
// steps (one quotient bit a cycle) and a result load; a zero weight sum or a
// full-scale cost skips the divide.
// Synchronous active-high reset restores the register defaults and clears both
// sums. A stalled result holds in its register; item_stall stays high until idle.
module masked_weighted_l1_patch_cost
  import mwl1_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [15:0] dense_weight;
  logic [7:0]  empty_code;
  logic [7:0]  target_code;

  // Control
  state_t      state;
  state_t      state_next;
  logic [3:0]  step;

  // Datapath registers
  item_t       held;
  logic [PROD_W-1:0] product;
  logic [15:0] weight;
  logic [DIST_W-1:0] distance_sum;
  logic [WSUM_W-1:0] weight_sum;
  logic [WSUM_W-1:0] rem;
  logic [15:0] quot;
  logic        zero_flag;

  // Combinational datapath
  logic        unknown;
  logic [7:0]  chosen;
  logic [7:0]  diff;
  logic [15:0] weight_sel;
  logic [DIST_W:0]   dist_add;
  logic [WSUM_W:0]   wsum_add;
  logic [WSUM_W:0]   rem_shift;
  logic [WSUM_W:0]   rem_sub;
  logic        cost_high;
  logic        item_take;
  logic        result_take;
  logic        load_result;

  assign item_take   = item_valid && !item_stall;
  assign result_take = result_valid && !result_stall;

  // Configuration writes; unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      dense_weight <= DENSE_WEIGHT_RST;
      empty_code   <= EMPTY_CODE_RST;
      target_code  <= TARGET_CODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DENSE_WEIGHT: dense_weight <= cfg_data;
        REG_EMPTY_CODE:   empty_code   <= cfg_data[7:0];
        REG_TARGET_CODE:  target_code  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Element select and absolute difference
  always_comb begin
    unknown    = (held.mask_status == empty_code) || (held.mask_status == target_code);
    chosen     = unknown ? held.dense_value : held.sparse_value;
    weight_sel = unknown ? dense_weight : UNIT_WEIGHT;
    diff       = (chosen >= held.dictionary_value) ? (chosen - held.dictionary_value)
                                                   : (held.dictionary_value - chosen);
  end

  // Saturating accumulate
  assign dist_add = {1'b0, distance_sum} + {{(DIST_W + 1 - PROD_W){1'b0}}, product};
  assign wsum_add = {1'b0, weight_sum} + {{(WSUM_W + 1 - 16){1'b0}}, weight};

  // Cost at or above 256.0 means the quotient has more than 16 bits.
  assign cost_high = distance_sum >= {weight_sum, 8'd0};

  // One restoring divide step: bring in the next dividend bit, try subtract.
  assign rem_shift = {rem, quot[15]};
  assign rem_sub   = rem_shift - {1'b0, weight_sum};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_take) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = held.last ? ST_PRE : ST_IDLE;
      ST_PRE: begin
        if (weight_sum == '0 || cost_high) state_next = ST_DONE;
        else                               state_next = ST_DIV;
      end
      ST_DIV:  if (step == 4'd15) state_next = ST_DONE;
      ST_DONE: if (!result_valid || result_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item_stall  = 1'b1;
    load_result = 1'b0;
    case (state)
      ST_IDLE: item_stall  = 1'b0;
      ST_DONE: load_result = !result_valid || result_take;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      distance_sum <= '0;
      weight_sum   <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ACC) begin
        distance_sum <= dist_add[DIST_W] ? {DIST_W{1'b1}} : dist_add[DIST_W-1:0];
        weight_sum   <= wsum_add[WSUM_W] ? {WSUM_W{1'b1}} : wsum_add[WSUM_W-1:0];
      end
      if (state == ST_PRE) step <= '0;
      else if (state == ST_DIV) step <= step + 4'd1;
      if (load_result) begin
        // Clear sums once the patch result is committed.
        distance_sum <= '0;
        weight_sum   <= '0;
        result_valid <= 1'b1;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_take) held <= item;
    if (state == ST_MUL) begin
      product <= PROD_W'(diff) * PROD_W'(weight_sel);
      weight  <= weight_sel;
    end
    case (state)
      ST_PRE: begin
        zero_flag <= (weight_sum == '0);
        rem       <= distance_sum[DIST_W-1:8];
        if (weight_sum == '0) quot <= '0;
        else if (cost_high)   quot <= COST_MAX;
        else                  quot <= {distance_sum[7:0], 8'd0};
      end
      ST_DIV: begin
        // quot shifts out dividend bits and shifts in quotient bits.
        if (!rem_sub[WSUM_W]) begin
          rem  <= rem_sub[WSUM_W-1:0];
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= rem_shift[WSUM_W-1:0];
          quot <= {quot[14:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_result) begin
      result.cost        <= (quot > COST_MAX) ? COST_MAX : quot;
      result.zero_weight <= zero_flag;
    end
  end

endmodule

`default_nettype wire
